/* sv/ypid_pkg.sv */
// shared types, register indexes and fixed-point helpers for the yaw-rate pid steering block
// depends on nothing; imported by ypid_mul, yaw_rate_pid_steering and the testbench
package ypid_pkg;

  // sequencer states; ST_MEAS, ST_PROP, ST_DIFF and ST_INTEG each make one multiplier pass
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MEAS   = 3'd1,
    ST_ERR    = 3'd2,
    ST_PROP   = 3'd3,
    ST_DIFF   = 3'd4,
    ST_INTEG  = 3'd5,
    ST_ICLAMP = 3'd6,
    ST_OUT    = 3'd7
  } state_e;

  // configuration register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DIFF_GAIN  = 3'd2,
    REG_OUT_MAX    = 3'd3,
    REG_OUT_MIN    = 3'd4,
    REG_INV_TRACK  = 3'd5
  } reg_idx_e;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned RndW   = ProdW - 8;
  localparam int unsigned AccW   = 37;

  localparam logic signed [15:0] OutMaxRst = 16'sh7fff;
  localparam logic signed [15:0] OutMinRst = -16'sh8000;
  localparam logic [15:0]        InvRst    = 16'd256;

  // clamp result: value and whether a limit was applied
  typedef struct packed {
    logic              hit;
    logic signed [15:0] val;
  } clamp_t;

  // round half up of p / 256: add one half, then floor shift
  function automatic logic signed [RndW-1:0] round_q8(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] q;
    q = p + ProdW'(128);
    return q[ProdW-1:8];
  endfunction

  // saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [RndW-1:0] v);
    logic signed [15:0] r;
    if (v > RndW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -RndW'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // upper limit wins, then lower limit, even when the limits cross
  function automatic clamp_t clamp_lim(input logic signed [RndW-1:0] v,
                                       input logic signed [15:0] lim_max,
                                       input logic signed [15:0] lim_min);
    clamp_t r;
    if (v > RndW'(lim_max)) begin
      r.hit = 1'b1;
      r.val = lim_max;
    end else if (v < RndW'(lim_min)) begin
      r.hit = 1'b1;
      r.val = lim_min;
    end else begin
      r.hit = 1'b0;
      r.val = v[15:0];
    end
    return r;
  endfunction

endpackage

/* sv/yaw_rate_pid_steering.sv */
// top level of the yaw-rate pid steering controller: apb registers, sequencer, output register
// depends on ypid_pkg and ypid_mul
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one control tick: left and right
//   wheel speeds and the target yaw rate, all signed Q7.8. Output channel
//   (out_valid_o / out_ready_i) returns one item per tick: clamped steering command,
//   measured yaw rate, the echoed target and a flag set when a limit was applied.
//   One item is worked at a time through four passes of a single shared 32x17
//   multiplier (measured rate, proportional, difference and integral products) under
//   the sequencer, which takes a new item only once it is back in idle. A finished
//   result sits in the output register; the next item may be accepted while it
//   waits. If the receiver still stalls when the following result is ready, the
//   sequencer holds in its last state until the register frees. Reset clears error
//   sum and previous error, sets gains to zero, limits to the full 16-bit range and
//   the track reciprocal to 1.0. Registers are written over the apb port at byte
//   address 4*index; the user must write them only while no item is in flight, as
//   the block does not enforce it.
module yaw_rate_pid_steering (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ypid_pkg::AddrW-1:0]    paddr,
  input  logic [ypid_pkg::DataW-1:0]    pwdata,
  output logic [ypid_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            left_speed_i,
  input  logic signed [15:0]            right_speed_i,
  input  logic signed [15:0]            target_rate_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            steer_angle_o,
  output logic signed [15:0]            measured_rate_o,
  output logic signed [15:0]            target_echo_o,
  output logic                          clamped_o
);
  import ypid_pkg::*;

  // configuration registers
  logic signed [15:0] prop_gain_q, integ_gain_q, diff_gain_q;
  logic signed [15:0] out_max_q, out_min_q;
  logic        [15:0] inv_track_q;

  // controller state
  logic signed [31:0] error_sum_q, error_sum_d;
  logic signed [16:0] prev_error_q;

  // per-item working registers
  state_e             state_q, state_d;
  logic signed [16:0] diff_lr_q;
  logic signed [15:0] target_q;
  logic signed [15:0] meas_q;
  logic signed [16:0] err_q;
  logic signed [17:0] dif_q;
  logic signed [AccW-1:0] acc_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] steer_q, meas_out_q, echo_q;
  logic               clamped_q;

  // sequencer outputs
  logic               mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic               load_out;
  logic signed [ProdW-1:0] prod;

  // datapath intermediates
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic signed [RndW-1:0] meas_rnd;
  logic signed [15:0] meas_sat;
  logic signed [16:0] err_new;
  logic signed [32:0] sum_full;
  clamp_t             integ_c;
  clamp_t             steer_c;
  logic signed [AccW-1:0] acc_rnd;
  logic signed [AccW-9:0] steer_raw;

  // apb write decode and read mux
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      diff_gain_q  <= '0;
      out_max_q    <= OutMaxRst;
      out_min_q    <= OutMinRst;
      inv_track_q  <= InvRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_q  <= pwdata[15:0];
        REG_INTEG_GAIN: integ_gain_q <= pwdata[15:0];
        REG_DIFF_GAIN:  diff_gain_q  <= pwdata[15:0];
        REG_OUT_MAX:    out_max_q    <= pwdata[15:0];
        REG_OUT_MIN:    out_min_q    <= pwdata[15:0];
        REG_INV_TRACK:  inv_track_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PROP_GAIN:  prdata = DataW'(prop_gain_q);
      REG_INTEG_GAIN: prdata = DataW'(integ_gain_q);
      REG_DIFF_GAIN:  prdata = DataW'(diff_gain_q);
      REG_OUT_MAX:    prdata = DataW'(out_max_q);
      REG_OUT_MIN:    prdata = DataW'(out_min_q);
      REG_INV_TRACK:  prdata = {16'd0, inv_track_q};
      default:        prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MEAS;
      ST_MEAS:   state_d = ST_ERR;
      ST_ERR:    state_d = ST_PROP;
      ST_PROP:   state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_ICLAMP;
      ST_ICLAMP: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operand select and handshakes
  always_comb begin
    in_ready_o = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MEAS: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(diff_lr_q);
        mul_b  = {1'b0, inv_track_q};
      end
      ST_PROP: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(err_q);
        mul_b  = MulBW'(prop_gain_q);
      end
      ST_DIFF: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(dif_q);
        mul_b  = MulBW'(diff_gain_q);
      end
      ST_INTEG: begin
        mul_en = 1'b1;
        mul_a  = error_sum_q;
        mul_b  = MulBW'(integ_gain_q);
      end
      ST_OUT: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // shared multiplier
  ypid_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // measured rate and error from the first product
  assign meas_rnd = round_q8(prod);
  assign meas_sat = sat16(meas_rnd);
  assign err_new  = 17'(target_q) - 17'(meas_sat);

  // saturating error sum
  assign sum_full = 33'(error_sum_q) + 33'(err_q);
  always_comb begin
    if (sum_full > 33'sh0_7fff_ffff) begin
      error_sum_d = 32'sh7fff_ffff;
    end else if (sum_full < -33'sh0_8000_0000) begin
      error_sum_d = -32'sh8000_0000;
    end else begin
      error_sum_d = sum_full[31:0];
    end
  end

  // integral term clamp, final rounding and clamp
  assign integ_c   = clamp_lim(round_q8(prod), out_max_q, out_min_q);
  assign acc_rnd   = acc_q + AccW'(128);
  assign steer_raw = acc_rnd[AccW-1:8];
  assign steer_c   = clamp_lim(RndW'(steer_raw), out_max_q, out_min_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      error_sum_q  <= '0;
      prev_error_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_PROP) begin
        error_sum_q  <= error_sum_d;
        prev_error_q <= err_q;
      end
    end
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_ready_i);

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          diff_lr_q <= 17'(right_speed_i) - 17'(left_speed_i);
          target_q  <= target_rate_i;
        end
      end
      ST_ERR: begin
        meas_q <= meas_sat;
        err_q  <= err_new;
      end
      ST_PROP: begin
        dif_q <= 18'(prev_error_q) - 18'(err_q);
      end
      ST_DIFF: begin
        acc_q <= prod[AccW-1:0];
      end
      ST_INTEG: begin
        acc_q <= acc_q + prod[AccW-1:0];
      end
      ST_ICLAMP: begin
        acc_q <= acc_q + {{(AccW-24){integ_c.val[15]}}, integ_c.val, 8'd0};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      steer_q    <= steer_c.val;
      clamped_q  <= steer_c.hit;
      meas_out_q <= meas_q;
      echo_q     <= target_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign steer_angle_o   = steer_q;
  assign measured_rate_o = meas_out_q;
  assign target_echo_o   = echo_q;
  assign clamped_o       = clamped_q;

endmodule

/* sv/ypid_mul.sv */
// shared signed multiplier with registered product, 32 x 17 bits
// depends on ypid_pkg
module ypid_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ypid_pkg::MulAW-1:0]   a_i,
  input  logic signed [ypid_pkg::MulBW-1:0]   b_i,
  output logic signed [ypid_pkg::ProdW-1:0]   prod_o
);
  import ypid_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;

  // full precision signed product
  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  // product register, loaded only on a working pass
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/ypid_chk.sv */
// port-level checker for yaw_rate_pid_steering, attached by bind
// depends on nothing beyond the top level's ports
module ypid_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] target_rate_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] steer_angle_o,
  input logic [15:0] measured_rate_o,
  input logic [15:0] target_echo_o,
  input logic        clamped_o
);

  logic [15:0] tgt_q;

  // target of the item last accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      tgt_q <= target_rate_i;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steer_angle_o) &&
      $stable(measured_rate_o) && $stable(target_echo_o) && $stable(clamped_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a new result frees the input side in the same cycle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result shown without finishing item");

  // a freshly loaded result echoes the target of the item just finished
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && target_echo_o == tgt_q)
    else $error("target echo mismatch");

endmodule

bind yaw_rate_pid_steering ypid_chk u_ypid_chk (.*);

/* tb/yaw_rate_pid_steering_tb.sv */
// self-checking testbench for the yaw-rate pid steering controller
// depends on ypid_pkg and yaw_rate_pid_steering; apb writes, bursty ticks, stalling receiver
// a scoreboard class predicts every result and compares it field by field
module yaw_rate_pid_steering_tb;
  import ypid_pkg::*;

  // register indexes past the last one, writes there must be ignored
  localparam int unsigned UnusedReg0 = 6;
  localparam int unsigned UnusedReg1 = 7;

  // one result item as the block should present it
  typedef struct {
    logic signed [15:0] steer;
    logic signed [15:0] meas;
    logic signed [15:0] echo;
    logic               clamped;
  } steer_result_t;

  // predictor of the controller plus the queue of results still to come
  class steer_scoreboard;
    logic signed [15:0] kp, ki, kd, lim_hi, lim_lo;
    logic [15:0]        inv_track;
    logic signed [31:0] err_acc;
    logic signed [16:0] last_err;
    steer_result_t      steer_q[$];
    int                 errors;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      lim_hi = 16'sh7fff;
      lim_lo = -16'sh8000;
      inv_track = 16'd256;
      err_acc = '0;
      last_err = '0;
      errors = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [15:0] v);
      case (idx)
        REG_PROP_GAIN:  kp = v;
        REG_INTEG_GAIN: ki = v;
        REG_DIFF_GAIN:  kd = v;
        REG_OUT_MAX:    lim_hi = v;
        REG_OUT_MIN:    lim_lo = v;
        REG_INV_TRACK:  inv_track = v;
        default: ;
      endcase
    endfunction

    // round half up of p / 256
    function longint rnd8(longint p);
      return (p + 64'sd128) >>> 8;
    endfunction

    // upper limit first, then lower, even when they cross
    function longint limit(longint v, output bit hit);
      hit = 1'b1;
      if (v > longint'(lim_hi)) return longint'(lim_hi);
      if (v < longint'(lim_lo)) return longint'(lim_lo);
      hit = 1'b0;
      return v;
    endfunction

    function int pending();
      return steer_q.size();
    endfunction

    // accepted tick: advance the loop state and queue the result
    function void note_tick(logic signed [15:0] l, logic signed [15:0] r,
                            logic signed [15:0] t);
      longint meas, err, dif, sum, integ, acc, steer;
      bit hit;
      steer_result_t res;
      meas = rnd8((longint'(r) - longint'(l)) * longint'(inv_track));
      if (meas > 32767) meas = 32767;
      if (meas < -32768) meas = -32768;
      err = longint'(t) - meas;
      dif = longint'(last_err) - err;
      sum = longint'(err_acc) + err;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      err_acc = sum[31:0];
      last_err = err[16:0];
      integ = limit(rnd8(sum * longint'(ki)), hit);
      acc = err * longint'(kp) + dif * longint'(kd) + integ * 256;
      steer = limit(rnd8(acc), hit);
      res.steer = steer[15:0];
      res.meas = meas[15:0];
      res.echo = t;
      res.clamped = hit;
      steer_q.push_back(res);
    endfunction

    // accepted result: compare with the oldest prediction
    function void check_steer(steer_result_t act);
      steer_result_t exp_r;
      if (steer_q.size() == 0) begin
        $error("unexpected result item: steer_angle %0d", act.steer);
        errors++;
        return;
      end
      exp_r = steer_q.pop_front();
      if (act.steer !== exp_r.steer) begin
        $error("steer_angle: expected %0d, actual %0d", exp_r.steer, act.steer);
        errors++;
      end
      if (act.meas !== exp_r.meas) begin
        $error("measured_rate: expected %0d, actual %0d", exp_r.meas, act.meas);
        errors++;
      end
      if (act.echo !== exp_r.echo) begin
        $error("target_echo: expected %0d, actual %0d", exp_r.echo, act.echo);
        errors++;
      end
      if (act.clamped !== exp_r.clamped) begin
        $error("clamped: expected %0b, actual %0b", exp_r.clamped, act.clamped);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [15:0]  left_speed_i, right_speed_i, target_rate_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic signed [15:0]  steer_angle_o, measured_rate_o, target_echo_o;
  logic                clamped_o;

  steer_scoreboard sb;

  // sender and receiver pacing
  bit tx_steady;
  bit rx_steady;
  int burst_left;
  bit rx_on;
  int rx_run;

  yaw_rate_pid_steering i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_speed_i   (left_speed_i),
    .right_speed_i  (right_speed_i),
    .target_rate_i  (target_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .steer_angle_o  (steer_angle_o),
    .measured_rate_o(measured_rate_o),
    .target_echo_o  (target_echo_o),
    .clamped_o      (clamped_o)
  );

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: alternating ready runs and stalls of random length
  always @(negedge clk_i) begin
    if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_run <= 0) begin
        rx_on = !rx_on;
        if (rx_on) rx_run = $urandom_range(1, 12);
        else if ($urandom_range(0, 7) == 0) rx_run = $urandom_range(8, 24);
        else rx_run = $urandom_range(1, 4);
      end
      out_ready_i <= rx_on;
      rx_run--;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    steer_result_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.steer = steer_angle_o;
      act.meas = measured_rate_o;
      act.echo = target_echo_o;
      act.clamped = clamped_o;
      sb.check_steer(act);
    end
  end

  // apb write, called and returning at a falling edge
  task automatic write_reg(int unsigned idx, logic [15:0] v);
    logic [15:0] upper;
    upper = 16'($urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx * 4);
    pwdata <= {upper, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                              logic [15:0] hi, logic [15:0] lo, logic [15:0] inv);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DIFF_GAIN, kd);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_INV_TRACK, inv);
  endtask

  // one tick item, called and returning at a falling edge
  task automatic send_tick(logic signed [15:0] l, logic signed [15:0] r,
                           logic signed [15:0] t);
    if (!tx_steady && burst_left <= 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(11, 30)) @(negedge clk_i);
      else repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    left_speed_i <= l;
    right_speed_i <= r;
    target_rate_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(l, r, t);
    burst_left--;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted result, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: pick_gain = 16'h8000;
      1: pick_gain = 16'h7fff;
      2: pick_gain = 16'h0000;
      3, 4: pick_gain = 16'($urandom_range(0, 1023)) - 16'd512;
      5: pick_gain = 16'($urandom);
      default: pick_gain = 16'($urandom_range(0, 2047)) - 16'd1024;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 7))
      0: pick_speed = 16'sh8000;
      1: pick_speed = 16'sh7fff;
      2: pick_speed = 16'sh0000;
      3: pick_speed = -16'sd1;
      4, 5: pick_speed = 16'($urandom_range(0, 1023)) - 16'sd512;
      default: pick_speed = 16'($urandom);
    endcase
  endfunction

  // random configuration, extremes included
  task automatic random_config();
    logic [15:0] hi, lo, inv, a;
    a = 16'($urandom_range(0, 32767));
    case ($urandom_range(0, 5))
      0: begin hi = 16'h7fff; lo = 16'h8000; end
      1: begin hi = 16'h8000; lo = 16'h7fff; end
      2: begin hi = 16'($urandom); lo = 16'($urandom); end
      default: begin hi = a; lo = -a; end
    endcase
    case ($urandom_range(0, 5))
      0: inv = 16'h0000;
      1: inv = 16'hffff;
      2: inv = 16'd256;
      3: inv = 16'($urandom);
      default: inv = 16'($urandom_range(64, 512));
    endcase
    apply_config(pick_gain(), pick_gain(), pick_gain(), hi, lo, inv);
  endtask

  // random ticks: tracking sequences with small errors mixed with raw fields
  task automatic random_phase(int n);
    logic signed [15:0] l, r, t;
    for (int i = 0; i < n; i++) begin
      l = pick_speed();
      r = pick_speed();
      t = pick_speed();
      if ($urandom_range(0, 2) == 0) begin
        l = 16'($urandom);
        r = l + 16'($urandom_range(0, 511)) - 16'sd256;
        t = 16'($urandom_range(0, 1023)) - 16'sd512;
      end else if ($urandom_range(0, 3) == 0) begin
        l = 16'($urandom);
        r = 16'($urandom);
        t = 16'($urandom);
      end
      send_tick(l, r, t);
      // sender holds off once per phase until the block is empty
      if (i == n / 2) wait_drained();
    end
  endtask

  // run limit
  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    burst_left = 0;
    rx_on = 1'b0;
    rx_run = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    left_speed_i = '0;
    right_speed_i = '0;
    target_rate_i = '0;
    out_ready_i = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration, measured rate saturating both ways
    send_tick(16'sd0, 16'sd0, 16'sd0);
    send_tick(-16'sd32768, 16'sd32767, 16'sd0);
    send_tick(16'sd32767, -16'sd32768, -16'sd32768);
    send_tick(16'sd100, -16'sd100, 16'sd32767);
    wait_drained();

    // moderate gains, narrow limits: both clamps hit
    apply_config(16'd256, 16'd64, 16'd128, 16'd4000, -16'd4000, 16'd200);
    send_tick(16'sd0, 16'sd0, 16'sd1000);
    send_tick(16'sd0, 16'sd0, -16'sd1000);
    send_tick(16'sd256, 16'sd512, 16'sd0);
    send_tick(-16'sd1, 16'sd0, 16'sd5);
    send_tick(16'sd0, 16'sd0, 16'sd32767);
    send_tick(16'sd0, 16'sd0, -16'sd32768);
    send_tick(16'sd12345, -16'sd12345, 16'sd77);
    send_tick(-16'sd32768, -16'sd32768, -16'sd32768);
    send_tick(16'sd32767, 16'sd32767, 16'sd32767);
    wait_drained();

    // crossed limits: upper limit wins
    write_reg(REG_OUT_MAX, -16'd100);
    write_reg(REG_OUT_MIN, 16'd100);
    send_tick(16'sd0, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sd5000);
    send_tick(16'sd0, 16'sd0, -16'sd5000);
    wait_drained();

    // extreme gains and largest track reciprocal
    apply_config(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
    send_tick(-16'sd32768, 16'sd32767, -16'sd32768);
    send_tick(16'sd32767, -16'sd32768, 16'sd32767);
    send_tick(16'sd1, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd1, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sd0);
    wait_drained();

    // zero track reciprocal, opposite extreme gains, writes to unused indexes
    apply_config(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000);
    write_reg(UnusedReg0, 16'($urandom));
    write_reg(UnusedReg1, 16'($urandom));
    send_tick(-16'sd32768, 16'sd32767, 16'sd32767);
    send_tick(16'sd5, -16'sd5, -16'sd32768);
    wait_drained();

    // error sum driven far positive then back through zero to far negative, no idling
    apply_config(16'd0, 16'd1, 16'd0, 16'h7fff, 16'h8000, 16'd256);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < 100; i++) send_tick(16'sd32767, -16'sd32768, 16'sd32767);
    for (int i = 0; i < 200; i++) send_tick(-16'sd32768, 16'sd32767, -16'sd32768);
    wait_drained();

    // random configurations and ticks under varying pacing
    for (int p = 0; p < 8; p++) begin
      tx_steady = (p % 4 == 2);
      rx_steady = (p % 4 == 3);
      random_config();
      random_phase(153);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
